/* rtl/periodic_image_generator_defines.svh */
// ----------------------------------------------------------------------------
// periodic_image_generator_defines
// Assertion macros shared by the periodic image generator RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_IMAGE_GENERATOR_DEFINES_SVH
`define PERIODIC_IMAGE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define PIG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic_image_generator: check failed");
// next-cycle implication, checked outside reset
`define PIG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic_image_generator: check failed");
`else
`define PIG_ASSERT_NOW(label, ante, cons)
`define PIG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/pig_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pig_pkg
// Widths, register indexes and the image combination table.
// ----------------------------------------------------------------------------
package pig_pkg;

    localparam int COORD_W   = 20;
    localparam int IMAGE_W   = 22;
    localparam int NUM_COMBO = 8;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [IMAGE_W-1:0] image_t;
    typedef logic [NUM_COMBO-1:0]      combo_mask_t;
    typedef logic [2:0]                axis_sel_t;   // {z, y, x}

    // register indexes
    localparam logic [1:0] REG_BOX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BOX_DEPTH  = 2'd2;
    localparam logic [1:0] REG_MARGIN     = 2'd3;

    localparam coord_t BOX_RESET    = '1;
    localparam coord_t MARGIN_RESET = '0;

    // emission order: original, x, y, z, xy, xz, yz, xyz
    function automatic axis_sel_t combo_sel(input logic [2:0] k);
        axis_sel_t s;
        case (k)
            3'd0:    s = 3'b000;
            3'd1:    s = 3'b001;
            3'd2:    s = 3'b010;
            3'd3:    s = 3'b100;
            3'd4:    s = 3'b011;
            3'd5:    s = 3'b101;
            3'd6:    s = 3'b110;
            3'd7:    s = 3'b111;
            default: s = 3'b000;
        endcase
        return s;
    endfunction

    // held position and its shifted coordinates
    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t pz;
        image_t nx;
        image_t ny;
        image_t nz;
    } held_item_t;

endpackage

/* rtl/periodic_image_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_image_generator
// Emits a particle position and its periodic images in a 3D box.
// ----------------------------------------------------------------------------
// The edge tests and the shifted coordinates are formed as a position is
// transferred in and held in one register; the image run is then sent one
// result per cycle, while out_ready allows, through an output register. An
// input of n results (1 to 8) occupies the block until its last result moves
// to the output register; the next position is taken in that same cycle, so
// single-result inputs stream at one per cycle when the output is not stalled.
// Box sizes and margin are written over the APB port at byte addresses 0, 4,
// 8 and 12.
`include "periodic_image_generator_defines.svh"

module periodic_image_generator (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [pig_pkg::ADDR_W-1:0] paddr,
    input  logic [pig_pkg::DATA_W-1:0] pwdata,
    output logic [pig_pkg::DATA_W-1:0] prdata,
    output logic                    pready,
    // positions
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pig_pkg::coord_t         pos_x,
    input  pig_pkg::coord_t         pos_y,
    input  pig_pkg::coord_t         pos_z,
    // images
    output logic                    out_valid,
    input  logic                    out_ready,
    output pig_pkg::image_t         image_x,
    output pig_pkg::image_t         image_y,
    output pig_pkg::image_t         image_z,
    output logic                    last_image
);

    import pig_pkg::*;

    coord_t      box_width_reg, box_height_reg, box_depth_reg, margin_reg;
    logic [1:0]  reg_index;
    logic        cfg_write;

    held_item_t  held_reg, held_next;
    combo_mask_t rem_reg, rem_next;
    logic        hold_valid_reg, hold_valid_next;

    image_t      img_x_reg, img_y_reg, img_z_reg;
    logic        last_reg;
    logic        out_valid_reg, out_valid_next;

    logic        in_xfer;
    logic        out_load;
    logic [2:0]  pick;
    axis_sel_t   sel;
    combo_mask_t rem_after;
    logic        run_done;
    axis_sel_t   need;
    combo_mask_t new_mask;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg  <= BOX_RESET;
            box_height_reg <= BOX_RESET;
            box_depth_reg  <= BOX_RESET;
            margin_reg     <= MARGIN_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_BOX_WIDTH:  box_width_reg  <= pwdata[COORD_W-1:0];
                REG_BOX_HEIGHT: box_height_reg <= pwdata[COORD_W-1:0];
                REG_BOX_DEPTH:  box_depth_reg  <= pwdata[COORD_W-1:0];
                REG_MARGIN:     margin_reg     <= pwdata[COORD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_index)
            REG_BOX_WIDTH:  prdata[COORD_W-1:0] = box_width_reg;
            REG_BOX_HEIGHT: prdata[COORD_W-1:0] = box_height_reg;
            REG_BOX_DEPTH:  prdata[COORD_W-1:0] = box_depth_reg;
            REG_MARGIN:     prdata[COORD_W-1:0] = margin_reg;
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // edge tests and shifted coordinates
    // ------------------------------------------------------------------
    function automatic logic axis_need(input coord_t pos, input coord_t size,
                                       input coord_t mrg);
        logic             low;
        logic             high;
        logic [COORD_W:0] reach;
        reach = {1'b0, pos} + {1'b0, mrg};
        low   = pos < mrg;
        high  = reach > {1'b0, size};
        return low || high;
    endfunction

    // low edge wins when both are crossed
    function automatic image_t axis_shift(input coord_t pos, input coord_t size,
                                          input coord_t mrg);
        image_t p;
        image_t s;
        p = image_t'({2'b00, pos});
        s = image_t'({2'b00, size});
        return (pos < mrg) ? p + s : p - s;
    endfunction

    always_comb
    begin
        need[0] = axis_need(pos_x, box_width_reg,  margin_reg);
        need[1] = axis_need(pos_y, box_height_reg, margin_reg);
        need[2] = axis_need(pos_z, box_depth_reg,  margin_reg);
        for (int k = 0; k < NUM_COMBO; k++)
        begin
            new_mask[k] = &(need | ~combo_sel(3'(k)));
        end
    end

    // ------------------------------------------------------------------
    // run sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        pick = '0;
        for (int k = NUM_COMBO - 1; k >= 0; k--)
        begin
            if (rem_reg[k])
                pick = 3'(k);
        end
    end

    always_comb
    begin
        rem_after       = rem_reg;
        rem_after[pick] = 1'b0;
    end

    assign sel      = combo_sel(pick);
    assign run_done = (rem_after == '0);
    assign out_load = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || (out_load && run_done);
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        held_next       = held_reg;
        rem_next        = rem_reg;
        hold_valid_next = hold_valid_reg;
        if (in_xfer)
        begin
            held_next.px    = pos_x;
            held_next.py    = pos_y;
            held_next.pz    = pos_z;
            held_next.nx    = axis_shift(pos_x, box_width_reg,  margin_reg);
            held_next.ny    = axis_shift(pos_y, box_height_reg, margin_reg);
            held_next.nz    = axis_shift(pos_z, box_depth_reg,  margin_reg);
            rem_next        = new_mask;
            hold_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            rem_next        = rem_after;
            hold_valid_next = !run_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg        <= rem_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            img_x_reg <= sel[0] ? held_reg.nx : image_t'({2'b00, held_reg.px});
            img_y_reg <= sel[1] ? held_reg.ny : image_t'({2'b00, held_reg.py});
            img_z_reg <= sel[2] ? held_reg.nz : image_t'({2'b00, held_reg.pz});
            last_reg  <= run_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign image_x    = img_x_reg;
    assign image_y    = img_y_reg;
    assign image_z    = img_z_reg;
    assign last_image = last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `PIG_ASSERT_NOW(a_hold_nonempty, hold_valid_reg, rem_reg != '0)
    `PIG_ASSERT_NOW(a_orig_first, in_xfer, new_mask[0])
    `PIG_ASSERT_NOW(a_take_on_finish, in_xfer && hold_valid_reg, out_load && run_done)
    `PIG_ASSERT_NEXT(a_load_shows, out_load, out_valid_reg)

endmodule
